@@ rtl/assert_macros.svh @@
// Assertion macros shared by the sorted list table RTL.
// Depends on nothing; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SLT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorted list table: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SLT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorted list table: next-cycle check failed");

`endif

@@ rtl/slt_pkg.sv @@
// Package for the sorted list table: payload structs, codes and the
// command/status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package slt_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
        logic [5:0]         position;
    } slt_in_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         entry_count;
    } slt_out_t;

    typedef enum logic [2:0] {
        RA_POS,
        RA_IDX_DEC1,
        RA_IDX_DEC2,
        RA_IDX_INC1,
        RA_IDX_INC2
    } rd_sel_t;

    typedef struct packed {
        logic       load_item;
        logic       idx_from_count;
        logic       idx_from_pos;
        logic       idx_inc;
        logic       idx_dec;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       wr_en;
        logic       wr_val;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       set_status;
        logic [1:0] status_code;
        logic       cap_rd;
        logic       res_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] item_func;
        logic       full;
        logic       empty;
        logic       pos_oor;
        logic       idx_zero;
        logic       idx_one;
        logic       idx_p1_lt_cnt;
        logic       idx_p2_lt_cnt;
        logic       val_lt_rd;
        logic       out_free;
    } dp_status_t;

endpackage

@@ rtl/slt_dpath.sv @@
// Datapath of the sorted list table: entry memory, count, index, pending
// result and output register. Depends on slt_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module slt_dpath
    import slt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  slt_in_t    s_data,
    output slt_out_t   m_data,
    output logic       m_valid,
    input  logic       m_ready,
    input  ctrl_cmd_t  cmd,
    output dp_status_t st
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    logic [31:0]        mem [CAPACITY];
    logic signed [31:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        wr_data;

    slt_in_t            item_reg;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [1:0]         pend_status_reg;
    logic signed [31:0] pend_rd_reg;
    slt_out_t           m_data_reg;
    logic               m_valid_reg, m_valid_next;
    logic [CW:0]        idx_ext;
    logic               out_free;

    assign idx_ext  = (CW + 1)'(idx_reg);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        unique case (cmd.rd_sel)
            RA_POS:      rd_addr = AW'(item_reg.position);
            RA_IDX_DEC1: rd_addr = idx_reg - AW'(1);
            RA_IDX_DEC2: rd_addr = idx_reg - AW'(2);
            RA_IDX_INC1: rd_addr = idx_reg + AW'(1);
            RA_IDX_INC2: rd_addr = idx_reg + AW'(2);
            default:     rd_addr = idx_reg;
        endcase
    end

    assign wr_data = cmd.wr_val ? item_reg.value : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[idx_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        idx_next = idx_reg;
        priority if (cmd.idx_from_count) begin
            idx_next = AW'(cnt_reg);
        end else if (cmd.idx_from_pos) begin
            idx_next = AW'(item_reg.position);
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + AW'(1);
        end else if (cmd.idx_dec) begin
            idx_next = idx_reg - AW'(1);
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        priority if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.set_status) begin
            pend_status_reg <= cmd.status_code;
            pend_rd_reg     <= '0;
        end
        if (cmd.cap_rd) begin
            pend_rd_reg <= rd_data_reg;
        end
        if (cmd.res_load) begin
            m_data_reg.read_value  <= pend_rd_reg;
            m_data_reg.status      <= pend_status_reg;
            m_data_reg.entry_count <= 7'(cnt_reg);
        end
    end

    assign st.item_func     = item_reg.func;
    assign st.full          = (cnt_reg == CW'(CAPACITY));
    assign st.empty         = (cnt_reg == '0);
    assign st.pos_oor       = (CMPW'(item_reg.position) >= CMPW'(cnt_reg));
    assign st.idx_zero      = (idx_reg == '0);
    assign st.idx_one       = (idx_reg == AW'(1));
    assign st.idx_p1_lt_cnt = ((idx_ext + (CW + 1)'(1)) < (CW + 1)'(cnt_reg));
    assign st.idx_p2_lt_cnt = ((idx_ext + (CW + 1)'(2)) < (CW + 1)'(cnt_reg));
    assign st.val_lt_rd     = (item_reg.value < rd_data_reg);
    assign st.out_free      = out_free;

    assign m_data  = m_data_reg;
    assign m_valid = m_valid_reg;

`include "assert_macros.svh"

    `SLT_ASSERT_IMPL(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CW'(CAPACITY))
    `SLT_ASSERT_IMPL(a_wr_in_list, aclk, aresetn, cmd.wr_en, CW'(idx_reg) <= cnt_reg)
    `SLT_ASSERT_IMPL(a_rd_wr_apart, aclk, aresetn, cmd.wr_en && cmd.rd_en, rd_addr != idx_reg)

endmodule

@@ rtl/slt_ctrl.sv @@
// Controller of the sorted list table: sequences decode, shift and result
// steps. Depends on slt_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module slt_ctrl
    import slt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_INS_SCAN = 8'b0000_0100,
        S_INS_CMP  = 8'b0000_1000,
        S_REM_SCAN = 8'b0001_0000,
        S_REM_MOVE = 8'b0010_0000,
        S_RD_WAIT  = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        cmd.rd_sel = RA_POS;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.set_status  = 1'b1;
                cmd.status_code = STAT_OK;
                state_next      = S_FINISH;
                unique case (st.item_func)
                    OP_INSERT: begin
                        if (st.full) begin
                            cmd.status_code = STAT_FULL;
                        end else begin
                            cmd.idx_from_count = 1'b1;
                            state_next         = S_INS_SCAN;
                        end
                    end
                    OP_REMOVE: begin
                        if (st.empty) begin
                            cmd.status_code = STAT_EMPTY;
                        end else if (st.pos_oor) begin
                            cmd.status_code = STAT_RANGE;
                        end else begin
                            cmd.idx_from_pos = 1'b1;
                            state_next       = S_REM_SCAN;
                        end
                    end
                    OP_READ: begin
                        if (st.pos_oor) begin
                            cmd.status_code = STAT_RANGE;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_POS;
                            state_next = S_RD_WAIT;
                        end
                    end
                    default: begin
                        cmd.status_code = STAT_OK;
                    end
                endcase
            end
            S_INS_SCAN: begin
                if (st.idx_zero) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_val  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX_DEC1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (st.val_lt_rd) begin
                    cmd.wr_en   = 1'b1;
                    cmd.idx_dec = 1'b1;
                    if (st.idx_one) begin
                        state_next = S_INS_SCAN;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_IDX_DEC2;
                    end
                end else begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_val  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_REM_SCAN: begin
                if (st.idx_p1_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX_INC1;
                    state_next = S_REM_MOVE;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_REM_MOVE: begin
                cmd.wr_en   = 1'b1;
                cmd.idx_inc = 1'b1;
                if (st.idx_p2_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX_INC2;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_RD_WAIT: begin
                cmd.cap_rd = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (st.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

`include "assert_macros.svh"

    `SLT_ASSERT_IMPL(a_res_needs_room, aclk, aresetn, cmd.res_load, st.out_free)
    `SLT_ASSERT_NEXT(a_load_to_decode, aclk, aresetn, cmd.load_item, state_reg == S_DECODE)

endmodule

@@ rtl/sorted_list_table_core.sv @@
// Sorted list table top level: joins controller and datapath.
// Depends on slt_pkg, slt_ctrl and slt_dpath.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_data   (slt_in_t)
//   m_        out        m_valid/m_ready    m_data   (slt_out_t)
//
// One transfer in at a time; s_ready is high only while the controller idles.
// Read: decode, a memory read, then finish. Insert: decode, then a scan down
// from the end that shifts each entry greater than the value up one place,
// then the write of the value. Remove: decode, then each entry above the
// position moves down one place. Errors and the spare code go from decode to
// finish. A stalled m_ side holds the result and blocks the next result only;
// reset clears the count and the output valid.
`timescale 1ns / 1ps

module sorted_list_table_core
    import slt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  slt_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output slt_out_t m_data
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    slt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    slt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .st      (st)
    );

endmodule
